FILE: hw/rtl/attempt_rate_limiter_lockout_defines.svh
// assertion macros for the attempt rate limiter
`ifndef ATTEMPT_RATE_LIMITER_LOCKOUT_DEFINES_SVH
`define ATTEMPT_RATE_LIMITER_LOCKOUT_DEFINES_SVH

// same-cycle implication check
`define ARLL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("attempt limiter check failed");

// next-cycle implication check
`define ARLL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("attempt limiter check failed");

`endif

FILE: hw/rtl/arll_pkg.sv
// shared types, constants and register codes for the attempt rate limiter
package arll_pkg;

   // field widths
   localparam int TIME_W       = 64;
   localparam int WINDOW_W     = 12;
   localparam int MAX_ATT_W    = 5;
   localparam int LOCKOUT_W    = 17;
   localparam int REMAIN_W     = 17;
   localparam int ATTEMPTS_W   = 5;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 17;

   // nanoseconds per second and derived product widths
   localparam int NS_W = 30;
   localparam logic [NS_W-1:0] NS_PER_SEC = NS_W'(1000000000);
   localparam int SPAN_W = WINDOW_W + NS_W;
   localparam int ADD_W  = LOCKOUT_W + NS_W;

   // divider geometry: a 64-bit value over 1e9 (at least 2^29) fits in QUOT_W bits
   localparam int QUOT_W     = TIME_W - (NS_W - 1);

   // upper-word fold: 2^32 = 4 * 1e9 + (FOLD_K << FOLD_SH)
   localparam int HALF_W     = 32;
   localparam int FOLD_W     = 18;
   localparam int FOLD_SH    = 11;
   localparam logic [FOLD_W-1:0] FOLD_K = FOLD_W'(144027);

   // ten folds bring any 64-bit value below 2^32; one spare fold, then the tail step
   localparam int DIV_CYCLES = 12;

   // defaults
   localparam int unsigned LOG_DEPTH_DEFAULT = 16;
   localparam logic [WINDOW_W-1:0]  WINDOW_RESET  = WINDOW_W'(60);
   localparam logic [MAX_ATT_W-1:0] MAX_ATT_RESET = MAX_ATT_W'(10);
   localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = LOCKOUT_W'(300);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ATT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT = 2'd2;

   // operation codes
   localparam logic OP_ATTEMPT = 1'b0;
   localparam logic OP_POLL    = 1'b1;

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CALC  = 6'b000010,
      ST_PRUNE = 6'b000100,
      ST_START = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

FILE: hw/rtl/arll_log_mem.sv
// timestamp log memory, one write and one registered read port
module arll_log_mem #(
   parameter int unsigned DEPTH = arll_pkg::LOG_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [arll_pkg::TIME_W-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [arll_pkg::TIME_W-1:0] rd_data
);
   import arll_pkg::*;

   logic [TIME_W-1:0] mem_ff [DEPTH];
   logic [TIME_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/arll_sec_div.sv
// multi-cycle divider by one billion: folds the upper word back as 2^32 mod 1e9
module arll_sec_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [arll_pkg::TIME_W-1:0] dividend,
   output arll_pkg::div_stat_type      stat,
   output logic [arll_pkg::QUOT_W-1:0] quotient
);
   import arll_pkg::*;

   localparam int CNT_W = $clog2(DIV_CYCLES + 1);
   localparam logic [HALF_W-1:0] SEC_1 = HALF_W'(NS_PER_SEC);
   localparam logic [HALF_W-1:0] SEC_2 = HALF_W'(64'd2000000000);
   localparam logic [HALF_W-1:0] SEC_3 = HALF_W'(64'd3000000000);
   localparam logic [HALF_W-1:0] SEC_4 = HALF_W'(64'd4000000000);

   logic [TIME_W-1:0]        rem_ff,  rem_in;
   logic [QUOT_W-1:0]        quot_ff, quot_in;
   logic [CNT_W-1:0]         cnt_ff,  cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [HALF_W-1:0]        rem_hi;
   logic [HALF_W-1:0]        rem_lo;
   logic [HALF_W+FOLD_W-1:0] fold;
   logic [TIME_W-1:0]        fold_sum;
   logic [2:0]               tail;

   // one fold per cycle: hi * 2^32 + lo = 4 * hi * 1e9 + hi * (2^32 mod 1e9) + lo
   assign rem_hi   = rem_ff[TIME_W-1:HALF_W];
   assign rem_lo   = rem_ff[HALF_W-1:0];
   assign fold     = rem_hi * FOLD_K;
   assign fold_sum = TIME_W'({fold, {FOLD_SH{1'b0}}}) + TIME_W'(rem_lo);

   // whole seconds left in a remainder below 2^32
   assign tail = (rem_lo >= SEC_4) ? 3'd4 :
                 (rem_lo >= SEC_3) ? 3'd3 :
                 (rem_lo >= SEC_2) ? 3'd2 :
                 (rem_lo >= SEC_1) ? 3'd1 : 3'd0;

   // sequencing of the folds and the tail step
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         quot_in = '0;
         cnt_in  = CNT_W'(DIV_CYCLES);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            quot_in = quot_ff + QUOT_W'(tail);
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            rem_in  = fold_sum;
            quot_in = quot_ff + QUOT_W'({rem_hi, 2'b00});
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;

endmodule

FILE: hw/rtl/attempt_rate_limiter_lockout.sv
// top level of the sliding-window attempt limiter with lockout
//
// usage:
// - request channel (req_): op and a nanosecond time stamp; a transaction moves
//   when req_valid is high and req_stall is low. op 0 is an attempt, op 1 a poll.
// - response channel (rsp_): allowed, locked_out, remaining_seconds and
//   attempts_in_window, one response per request, in order.
// - csr_ port: window, attempt limit and lockout length, written while idle.
// - path from request to response register: a poll or a locked-out attempt skips
//   the log walk; any other attempt walks the log and drops expired entries. The
//   log walk reads one entry per cycle from the log memory,
//   and the seconds divider holds the sequencer in ST_DIV until it is done.
// - one request at a time; a new request is taken as soon as the previous
//   result sits in the response register, even while that response is stalled.
// - when rsp_stall holds a response, the next result waits inside the block
//   and req_stall stays high until it can move into the response register.
// - reset clears the log count, head, lockout end and registers to defaults;
//   the log memory needs no clearing pass.
`include "attempt_rate_limiter_lockout_defines.svh"

module attempt_rate_limiter_lockout #(
   parameter int unsigned LOG_DEPTH = arll_pkg::LOG_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [arll_pkg::TIME_W-1:0]     req_time_ns,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_allowed,
   output logic                            rsp_locked_out,
   output logic [arll_pkg::REMAIN_W-1:0]   rsp_remaining_seconds,
   output logic [arll_pkg::ATTEMPTS_W-1:0] rsp_attempts_in_window,
   input  logic                            csr_we,
   input  logic [arll_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [arll_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import arll_pkg::*;

   localparam int ADDR_W = $clog2(LOG_DEPTH);
   localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
   localparam int LIM_W  = (CNT_W > MAX_ATT_W) ? CNT_W : MAX_ATT_W;
   localparam int SUM_W  = CNT_W + 1;

   state_type              state_ff, state_in;
   logic                   op_ff;
   logic [TIME_W-1:0]      now_ff;
   logic [TIME_W-1:0]      cutoff_ff, cutoff_in;
   logic [SPAN_W-1:0]      span_ff;
   logic [ADD_W-1:0]       add_ff;
   logic [WINDOW_W-1:0]    window_ff;
   logic [MAX_ATT_W-1:0]   max_att_ff;
   logic [LOCKOUT_W-1:0]   lockout_sec_ff;
   logic [ADDR_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [TIME_W-1:0]      lockout_end_ff, lockout_end_in;
   logic                   allowed_ff, allowed_in;
   logic                   locked_ff, locked_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_allowed_ff;
   logic                   rsp_locked_ff;
   logic [REMAIN_W-1:0]    rsp_remain_ff;
   logic [ATTEMPTS_W-1:0]  rsp_attempts_ff;

   logic                   req_accept;
   logic                   rsp_load;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [TIME_W-1:0]      rd_data;
   logic [ADDR_W-1:0]      head_inc;
   logic [SUM_W-1:0]       wr_sum;
   logic [LIM_W-1:0]       limit;
   logic [LIM_W-1:0]       count_ext;
   logic                   drop;
   logic [TIME_W:0]        end_sum;
   logic [TIME_W-1:0]      end_sat;
   logic                   div_start;
   div_stat_type           div_stat;
   logic [QUOT_W-1:0]      quotient;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // configuration registers and their nanosecond products
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= WINDOW_RESET;
         max_att_ff     <= MAX_ATT_RESET;
         lockout_sec_ff <= LOCKOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW:  window_ff      <= csr_wdata[WINDOW_W-1:0];
            CSR_MAX_ATT: max_att_ff     <= csr_wdata[MAX_ATT_W-1:0];
            CSR_LOCKOUT: lockout_sec_ff <= csr_wdata[LOCKOUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= window_ff * NS_PER_SEC;
      add_ff  <= lockout_sec_ff * NS_PER_SEC;
   end

   // log index arithmetic
   assign head_inc  = (head_ff == ADDR_W'(LOG_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign wr_sum    = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign wr_addr   = (wr_sum >= SUM_W'(LOG_DEPTH)) ? ADDR_W'(wr_sum - SUM_W'(LOG_DEPTH))
                                                    : ADDR_W'(wr_sum);
   assign limit     = (LIM_W'(max_att_ff) > LIM_W'(LOG_DEPTH)) ? LIM_W'(LOG_DEPTH)
                                                                : LIM_W'(max_att_ff);
   assign count_ext = LIM_W'(count_ff);
   assign drop      = (count_ff != '0) && (rd_data < cutoff_ff);

   // saturating lockout end
   assign end_sum = {1'b0, now_ff} + (TIME_W + 1)'(add_ff);
   assign end_sat = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cutoff_in      = cutoff_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      lockout_end_in = lockout_end_ff;
      allowed_in     = allowed_ff;
      locked_in      = locked_ff;
      wr_en          = 1'b0;
      rd_addr        = head_ff;
      div_start      = 1'b0;
      rsp_load       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            allowed_in = 1'b0;
            if (req_valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cutoff_in = (now_ff >= TIME_W'(span_ff)) ? now_ff - TIME_W'(span_ff) : '0;
            if ((op_ff == OP_POLL) || (lockout_end_ff > now_ff)) begin
               state_in = ST_START;
            end else begin
               state_in = ST_PRUNE;
            end
         end
         ST_PRUNE: begin
            if (drop) begin
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
               rd_addr  = head_inc;
            end else if (count_ext >= limit) begin
               lockout_end_in = end_sat;
               state_in       = ST_START;
            end else begin
               wr_en      = 1'b1;
               count_in   = count_ff + 1'b1;
               allowed_in = 1'b1;
               state_in   = ST_START;
            end
         end
         ST_START: begin
            locked_in = (lockout_end_ff > now_ff);
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         count_ff       <= '0;
         lockout_end_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         count_ff       <= count_in;
         lockout_end_ff <= lockout_end_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // transaction and working registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_op;
         now_ff <= req_time_ns;
      end
      cutoff_ff  <= cutoff_in;
      allowed_ff <= allowed_in;
      locked_ff  <= locked_in;
   end

   // response payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_allowed_ff  <= allowed_ff;
         rsp_locked_ff   <= locked_ff;
         rsp_remain_ff   <= locked_ff ? quotient[REMAIN_W-1:0] : '0;
         rsp_attempts_ff <= count_ext[ATTEMPTS_W-1:0];
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_allowed            = rsp_allowed_ff;
   assign rsp_locked_out         = rsp_locked_ff;
   assign rsp_remaining_seconds  = rsp_remain_ff;
   assign rsp_attempts_in_window = rsp_attempts_ff;

   // timestamp log
   arll_log_mem #(
      .DEPTH(LOG_DEPTH)
   ) u_log_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(now_ff),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // remaining lockout seconds
   arll_sec_div u_sec_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(lockout_end_ff - now_ff),
      .stat    (div_stat),
      .quotient(quotient)
   );

   // checks
   `ARLL_ASSERT_SAME(a_allowed_not_locked, clock, reset, rsp_valid && rsp_allowed, !rsp_locked_out)
   `ARLL_ASSERT_SAME(a_unlocked_no_remain, clock, reset, rsp_valid && !rsp_locked_out, rsp_remaining_seconds == '0)
   `ARLL_ASSERT_NEXT(a_log_write_counts, clock, reset, wr_en, count_ff == $past(count_ff) + CNT_W'(1))
   `ARLL_ASSERT_SAME(a_div_start_free, clock, reset, div_start, !div_stat.busy)

endmodule
